[rtl/wrlt_pkg.sv]
`timescale 1ns / 1ps
package wrlt_pkg;
  localparam int unsigned TableSlotsDefault = 1024;
  localparam logic [31:0] HashMult = 32'h7feb352d;
  localparam logic [63:0] MaxLatency = 64'd10000000000;
  localparam int unsigned EntryW = 1 + 22 + 64 + 11;

  typedef enum logic [1:0] {
    ActWakeup = 2'd0,
    ActSwitch = 2'd1,
    ActMigrate = 2'd2,
    ActCleanup = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    OutFiltered = 4'd0,
    OutInserted = 4'd1,
    OutEvicted = 4'd2,
    OutReported = 4'd3,
    OutBelowMin = 4'd4,
    OutMissAbsent = 4'd5,
    OutMissBack = 4'd6,
    OutMissOld = 4'd7,
    OutMigrated = 4'd8,
    OutMigAbsent = 4'd9,
    OutCleanDone = 4'd10
  } outcome_e;

  typedef enum logic [1:0] {
    CfgMinLat = 2'd0,
    CfgExport = 2'd1,
    CfgKeep = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StHash,
    StMod,
    StScan,
    StWrite,
    StDone
  } state_e;

  typedef struct packed {
    logic        valid;
    logic [21:0] task_id;
    logic [63:0] wake_time;
    logic [10:0] cpu;
  } entry_t;
endpackage

[rtl/wrlt_ram.sv]
`timescale 1ns / 1ps
module wrlt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[rtl/wakeup_to_run_latency_tracker_unit.sv]
`timescale 1ns / 1ps
// Channel  | Signals                                   | Handshake
// command  | start_i, busy_o, action_i .. target_match_i| start_i && !busy_o
// result   | done_o, outcome_o .. freed_count_o        | one-cycle strobe
// config   | cfg_valid_i, cfg_ready_o, cfg_index_i/data | valid && ready
//
// Strobe path after the accepting edge: a filtered wakeup goes StHash, StDone; lookups go
// StHash, StMod, StScan over the probes (up to TableSlots, one slot per cycle off the RAM
// read port), StWrite only for a wakeup that writes a new slot, then StDone. Cleanup walks
// every slot. Reset runs a clearing pass over the entry RAM with busy_o high.
// Results cannot be stalled; busy_o drops in the strobe cycle, so the next request can be
// accepted at the edge that ends it.
module wakeup_to_run_latency_tracker_unit #(
  parameter int unsigned TableSlots = wrlt_pkg::TableSlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [21:0] task_id_i,
  input  logic [63:0] event_time_i,
  input  logic signed [10:0] event_cpu_i,
  input  logic signed [10:0] other_cpu_i,
  input  logic [21:0] outgoing_task_i,
  input  logic        target_match_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output logic        done_o,
  output logic [3:0]  outcome_o,
  output logic [21:0] report_task_o,
  output logic [63:0] wake_time_o,
  output logic [63:0] run_time_o,
  output logic [33:0] latency_o,
  output logic [21:0] preempter_task_o,
  output logic signed [10:0] run_cpu_o,
  output logic        migrated_o,
  output logic        export_flag_o,
  output logic [10:0] freed_count_o
);
  import wrlt_pkg::*;

  localparam int unsigned AW = $clog2(TableSlots);
  localparam int unsigned CW = $clog2(TableSlots + 1);
  // floor(2^32 / TableSlots): quotient estimate for the home-slot reduction
  localparam logic [31:0] Recip = 32'((64'd1 << 32) / TableSlots);

  state_e state_q, state_d;
  logic [33:0] min_lat_q, export_q;
  logic [63:0] keep_q;

  // latched request
  logic [1:0] act_q;
  logic [21:0] task_q, prev_q;
  logic [63:0] time_q;
  logic [10:0] ecpu_q, ocpu_q;
  logic match_q;

  logic [31:0] hash_q, mix_q, quot_q;
  logic [AW-1:0] raddr_q, raddr_d;   // address being read (data next cycle)
  logic [AW-1:0] paddr_q;            // address whose data is on rdata
  logic [AW-1:0] clr_q;              // clearing pass address
  logic pend_q;                      // rdata valid for paddr_q
  logic [CW-1:0] seen_q;
  logic empty_v_q, old_v_q;
  logic [AW-1:0] empty_a_q, old_a_q;
  logic [63:0] old_t_q;
  logic [10:0] freed_q;

  logic we;
  logic [AW-1:0] waddr;
  entry_t wdata, rdata;

  wrlt_ram #(.Width(EntryW), .Depth(TableSlots)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr_q), .rdata_o(rdata)
  );

  assign cfg_ready_o = (state_q == StIdle) && !start_i;
  assign busy_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_lat_q <= '0;
      export_q <= '0;
      keep_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgMinLat: min_lat_q <= cfg_data_i[33:0];
        CfgExport: export_q <= cfg_data_i[33:0];
        CfgKeep:   keep_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // hash stages: x ^= x>>16 and multiply on accept, then mix and reciprocal estimate,
  // then remainder with one corrective subtract
  logic [31:0] x0, mixed;
  assign x0 = {10'd0, task_id_i} ^ ({10'd0, task_id_i} >> 16);
  assign mixed = hash_q ^ (hash_q >> 15);
  logic [63:0] prod;
  assign prod = {32'd0, mixed} * {32'd0, Recip};
  logic [31:0] rem0, rem1;
  assign rem0 = mix_q - quot_q * 32'(TableSlots);
  assign rem1 = (rem0 >= 32'(TableSlots)) ? rem0 - 32'(TableSlots) : rem0;
  logic [AW-1:0] home;
  assign home = AW'(rem1);

  logic [AW-1:0] next_addr;
  assign next_addr = (raddr_q == AW'(TableSlots - 1)) ? '0 : raddr_q + 1'b1;

  // evaluate slot whose data is back
  logic cur_valid, cur_hit;
  logic [63:0] lat;
  assign cur_valid = pend_q && rdata.valid;
  assign cur_hit = cur_valid && (rdata.task_id == task_q);
  assign lat = time_q - rdata.wake_time;

  logic scan_all;
  assign scan_all = (act_q == ActCleanup);
  logic last_seen;
  assign last_seen = pend_q && (seen_q == CW'(TableSlots - 1));

  // result staging
  logic [3:0] res_out;
  logic res_mig, res_exp;
  logic [63:0] res_wake;
  logic [33:0] res_lat;

  logic finish, stale;
  assign stale = cur_valid && (time_q >= rdata.wake_time) && (lat > keep_q);

  // wakeup without hit goes through the StWrite state
  logic need_write;
  assign need_write = (act_q == ActWakeup) && !cur_hit;

  always_comb begin
    state_d = state_q;
    raddr_d = raddr_q;
    case (state_q)
      StClear: if (clr_q == AW'(TableSlots - 1)) state_d = StIdle;
      StIdle:  if (start_i) state_d = StHash;
      StHash:  state_d = (act_q == ActWakeup && !match_q) ? StDone : StMod;
      StMod:   begin
        raddr_d = scan_all ? '0 : home;
        state_d = StScan;
      end
      StScan:  begin
        raddr_d = next_addr;
        if (finish) state_d = need_write ? StWrite : StDone;
      end
      StWrite: state_d = StDone;
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign finish = (!scan_all && cur_hit) || last_seen;

  always_comb begin
    we = 1'b0;
    waddr = paddr_q;
    wdata.valid = 1'b1;
    wdata.task_id = task_q;
    wdata.wake_time = time_q;
    wdata.cpu = ocpu_q[10] ? ecpu_q : ocpu_q;
    if (state_q == StClear) begin
      we = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end
    if (state_q == StScan && pend_q) begin
      if (act_q == ActWakeup && cur_hit) we = 1'b1;
      if (act_q == ActSwitch && cur_hit) begin
        we = 1'b1;
        wdata = '0;
      end
      if (act_q == ActMigrate && cur_hit) begin
        we = 1'b1;
        wdata = rdata;
        wdata.cpu = ocpu_q;
      end
      if (act_q == ActCleanup && stale) begin
        we = 1'b1;
        wdata = '0;
      end
    end
    if (state_q == StWrite) begin
      we = 1'b1;
      waddr = empty_v_q ? empty_a_q : old_a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      done_o <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o <= 1'b0;
      if (state_q == StClear) clr_q <= clr_q + 1'b1;
      if (state_q == StHash) begin
        pend_q <= 1'b0;
      end else begin
        pend_q <= (state_q == StScan) && !finish;
      end
      if (state_q == StDone) done_o <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      act_q <= action_i;
      task_q <= task_id_i;
      prev_q <= outgoing_task_i;
      time_q <= event_time_i;
      ecpu_q <= event_cpu_i;
      ocpu_q <= other_cpu_i;
      match_q <= target_match_i;
    end
    raddr_q <= raddr_d;
    paddr_q <= raddr_q;
    if (state_q == StIdle) hash_q <= 32'(x0 * HashMult);
    if (state_q == StHash) begin
      mix_q <= mixed;
      quot_q <= prod[63:32];
      seen_q <= '0;
      empty_v_q <= 1'b0;
      old_v_q <= 1'b0;
      freed_q <= '0;
      res_out <= OutFiltered;
      res_mig <= 1'b0;
      res_exp <= 1'b0;
    end
    if (state_q == StScan && pend_q) begin
      seen_q <= seen_q + 1'b1;
      if (!rdata.valid && !empty_v_q) begin
        empty_v_q <= 1'b1;
        empty_a_q <= paddr_q;
      end
      if (cur_valid && (!old_v_q || rdata.wake_time < old_t_q)) begin
        old_v_q <= 1'b1;
        old_a_q <= paddr_q;
        old_t_q <= rdata.wake_time;
      end
      if (stale) freed_q <= freed_q + 1'b1;
    end
    if (state_q == StScan && finish) begin
      case (action_e'(act_q))
        ActWakeup: res_out <= cur_hit ? OutInserted
                                      : ((empty_v_q || (pend_q && !rdata.valid))
                                         ? OutInserted : OutEvicted);
        ActSwitch: begin
          if (!cur_hit) res_out <= OutMissAbsent;
          else if (time_q < rdata.wake_time) res_out <= OutMissBack;
          else if (lat > MaxLatency) res_out <= OutMissOld;
          else if (lat[33:0] >= min_lat_q) res_out <= OutReported;
          else res_out <= OutBelowMin;
          res_mig <= !rdata.cpu[10] && !ecpu_q[10] && (rdata.cpu != ecpu_q);
          res_exp <= lat[33:0] >= export_q;
          res_wake <= rdata.wake_time;
          res_lat <= lat[33:0];
        end
        ActMigrate: res_out <= cur_hit ? OutMigrated : OutMigAbsent;
        default:   res_out <= OutCleanDone;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outcome_o <= '0;
    end else if (state_q == StDone) begin
      outcome_o <= (act_q == ActWakeup && !match_q) ? OutFiltered : res_out;
    end
  end

  logic rep;
  assign rep = (outcome_o == OutReported);
  assign report_task_o = rep ? task_q : '0;
  assign wake_time_o = rep ? res_wake : '0;
  assign run_time_o = rep ? time_q : '0;
  assign latency_o = rep ? res_lat : '0;
  assign preempter_task_o = rep ? prev_q : '0;
  assign run_cpu_o = rep ? ecpu_q : '0;
  assign migrated_o = rep && res_mig;
  assign export_flag_o = rep && res_exp;
  assign freed_count_o = (outcome_o == OutCleanDone) ? freed_q : '0;
endmodule
